### rtl/mwdm_pkg.sv
// Shared constants, types and duty saturation for the mecanum wheel duty mixer.
`default_nettype none
package mwdm_pkg;

   localparam int NumWheels   = 4;
   localparam int StickW      = 8;
   localparam int DeadW       = 8;
   localparam int DutyW       = 10;
   localparam int SumW        = 14;
   localparam int DutyMax     = 999;
   localparam int StickCenter = 128;
   localparam int Deadband    = 3;
   localparam int StickLow    = StickCenter - Deadband;
   localparam int StickHigh   = StickCenter + Deadband;

   localparam int CsrIndexW   = 3;
   localparam logic [CsrIndexW-1:0] CsrDeadA = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrDeadB = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrDeadC = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrDeadD = 3'd3;
   localparam logic [DeadW-1:0]     DeadReset = 8'd90;

   typedef logic [NumWheels-1:0][DeadW-1:0] dead_arr_type;

   typedef struct packed {
      logic [NumWheels-1:0][DutyW-1:0] duty;
      logic [NumWheels-1:0]            fwd;
   } mix_result_type;

   // magnitude of sum/4 truncated toward zero, clipped to the duty ceiling
   function automatic logic [DutyW-1:0] duty_sat(input logic signed [SumW-1:0] sum);
      logic [SumW-1:0]   mag;
      logic [SumW-3:0]   quo;
      mag = sum[SumW-1] ? $unsigned(-sum) : $unsigned(sum);
      quo = mag[SumW-1:2];
      return (quo > (SumW-2)'(DutyMax)) ? DutyW'(DutyMax) : quo[DutyW-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/mecanum_wheel_duty_mixer_core.sv
// Top level of the mecanum wheel duty mixer: input stage, result stage, CSRs.
//
// Usage:
//   req_* carries one joystick sample (x, y, z, centre 128) per beat; a beat is
//   taken on a rising edge with req_valid high and req_stall low.
//   rsp_* returns one beat per sample: four duties (0..999) and four
//   direction bits; the receiver holds rsp_stall high to pause it.
//   csr_* writes the four dead-width registers (index 0..3, others ignored);
//   write only while no sample is in flight.
// Path: a request beat reaches the response through the input register,
//   then the result register, with the mixing logic between them.
// Throughput: one sample per cycle while the result stage is not stalled;
//   while a result waits to be taken, the input stage takes at most one beat.
// Reset (synchronous): both stages empty, dead widths 90, direction state
//   set backward for all motors.
// Stall: a stalled result holds; the input stage then fills and req_stall
//   rises until the result beat is taken.
`default_nettype none
module mecanum_wheel_duty_mixer_core
   import mwdm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [StickW-1:0]    req_stick_x,
   input  wire logic [StickW-1:0]    req_stick_y,
   input  wire logic [StickW-1:0]    req_stick_z,

   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [DutyW-1:0]     rsp_duty_one,
   output      logic [DutyW-1:0]     rsp_duty_two,
   output      logic [DutyW-1:0]     rsp_duty_three,
   output      logic [DutyW-1:0]     rsp_duty_four,
   output      logic                 rsp_fwd_one,
   output      logic                 rsp_fwd_two,
   output      logic                 rsp_fwd_three,
   output      logic                 rsp_fwd_four,

   input  wire logic                 csr_write_enable,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [DeadW-1:0]     csr_wdata
);

   dead_arr_type               dead_ff;
   logic [NumWheels-1:0]       dir_ff;
   logic                       s1_valid_ff;
   logic [StickW-1:0]          s1_x_ff;
   logic [StickW-1:0]          s1_y_ff;
   logic [StickW-1:0]          s1_z_ff;
   logic                       s2_valid_ff;
   mix_result_type             s2_res_ff;
   mix_result_type             s2_res_in;
   logic                       s2_free;
   logic                       s1_move;
   logic                       req_take;

   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;

   mwdm_mix u_mix (
      .stick_x    (s1_x_ff),
      .stick_y    (s1_y_ff),
      .stick_z    (s1_z_ff),
      .dead_width (dead_ff),
      .dir_prev   (dir_ff),
      .result     (s2_res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff <= {NumWheels{DeadReset}};
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrDeadA: dead_ff[0] <= csr_wdata;
            CsrDeadB: dead_ff[1] <= csr_wdata;
            CsrDeadC: dead_ff[2] <= csr_wdata;
            CsrDeadD: dead_ff[3] <= csr_wdata;
            default:  dead_ff    <= dead_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         dir_ff      <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_valid_ff <= 1'b1;
            dir_ff      <= s2_res_in.fwd;
         end else if (s2_free) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_x_ff <= req_stick_x;
         s1_y_ff <= req_stick_y;
         s1_z_ff <= req_stick_z;
      end
      if (s1_move) begin
         s2_res_ff <= s2_res_in;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_duty_one   = s2_res_ff.duty[0];
   assign rsp_duty_two   = s2_res_ff.duty[1];
   assign rsp_duty_three = s2_res_ff.duty[2];
   assign rsp_duty_four  = s2_res_ff.duty[3];
   assign rsp_fwd_one    = s2_res_ff.fwd[0];
   assign rsp_fwd_two    = s2_res_ff.fwd[1];
   assign rsp_fwd_three  = s2_res_ff.fwd[2];
   assign rsp_fwd_four   = s2_res_ff.fwd[3];

`ifndef SYNTH
   a_dir_only_on_move: assert property (@(posedge clock) disable iff (reset)
      !$past(s1_move) |-> $stable(dir_ff))
      else $error("direction state changed without a stage move");

   a_fwd_matches_state: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_res_ff.fwd == dir_ff))
      else $error("result direction differs from direction state");

   a_duty_ceiling: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_res_ff.duty[0] <= DutyW'(DutyMax)) &&
                      (s2_res_ff.duty[1] <= DutyW'(DutyMax)) &&
                      (s2_res_ff.duty[2] <= DutyW'(DutyMax)) &&
                      (s2_res_ff.duty[3] <= DutyW'(DutyMax)))
      else $error("duty above ceiling");

   a_s1_held_when_blocked: assert property (@(posedge clock) disable iff (reset)
      $past(s1_valid_ff && !s1_move) |-> s1_valid_ff)
      else $error("input stage dropped a beat");
`endif

endmodule
`default_nettype wire

### rtl/mwdm_mix.sv
// Combinational wheel mixing: mode select, per-wheel duty and direction update.
`default_nettype none
module mwdm_mix
   import mwdm_pkg::*;
(
   input  wire logic [StickW-1:0]    stick_x,
   input  wire logic [StickW-1:0]    stick_y,
   input  wire logic [StickW-1:0]    stick_z,
   input  wire dead_arr_type         dead_width,
   input  wire logic [NumWheels-1:0] dir_prev,
   output mix_result_type            result
);

   logic                     trans_mode;
   logic                     rot_mode;
   logic signed [9:0]        sxy;
   logic signed [8:0]        dyx;
   logic [8:0]               abs_sxy;
   logic [7:0]               abs_dyx;
   logic [9:0]               p;
   logic [9:0]               q;
   logic signed [7:0]        t;
   logic signed [11:0]       t12;
   logic signed [NumWheels-1:0][11:0] v;
   logic [7:0]               m;
   logic [9:0]               five_m;
   logic [8:0]               a;
   logic [11:0]              five_a;
   logic signed [SumW-1:0]   v14;
   logic signed [SumW-1:0]   sum;

   assign trans_mode = (stick_x < StickW'(StickLow)) || (stick_x > StickW'(StickHigh)) ||
                       (stick_y < StickW'(StickLow)) || (stick_y > StickW'(StickHigh));
   assign rot_mode   = (stick_z < StickW'(StickLow)) || (stick_z > StickW'(StickHigh));

   assign sxy     = $signed(10'd256) - $signed({2'b00, stick_x}) - $signed({2'b00, stick_y});
   assign dyx     = $signed({1'b0, stick_y}) - $signed({1'b0, stick_x});
   assign abs_sxy = sxy[9] ? 9'(-sxy) : sxy[8:0];
   assign abs_dyx = dyx[8] ? 8'(-dyx) : dyx[7:0];
   assign p       = {abs_sxy, 1'b0} + {1'b0, abs_sxy};
   assign q       = {1'b0, abs_dyx, 1'b0} + {2'b00, abs_dyx};
   assign t       = $signed({~stick_z[7], stick_z[6:0]});
   assign t12     = $signed({{4{t[7]}}, t});

   assign v[0] = $signed({2'b00, p}) - t12;
   assign v[1] = $signed({2'b00, q}) + t12;
   assign v[2] = $signed({2'b00, p}) + t12;
   assign v[3] = $signed({2'b00, q}) - t12;

   assign m      = t[7] ? 8'(-t) : {1'b0, t[6:0]};
   assign five_m = {m, 2'b00} + {2'b00, m};
   assign a      = five_m[9:1];
   assign five_a = {1'b0, a, 2'b00} + {3'b000, a};

   always_comb begin
      result.duty = '0;
      result.fwd  = dir_prev;
      v14         = '0;
      sum         = '0;
      if (trans_mode) begin
         for (int k = 0; k < NumWheels; k++) begin
            v14 = $signed({{2{v[k][11]}}, v[k]});
            sum = (v14 <<< 2) + v14 + $signed({4'b0000, dead_width[k], 2'b00});
            result.duty[k] = duty_sat(sum);
         end
         if (sxy < 0) begin
            result.fwd[0] = 1'b1;
            result.fwd[2] = 1'b0;
         end else if (sxy > 0) begin
            result.fwd[0] = 1'b0;
            result.fwd[2] = 1'b1;
         end
         if (dyx > 0) begin
            result.fwd[1] = 1'b0;
            result.fwd[3] = 1'b1;
         end else if (dyx < 0) begin
            result.fwd[1] = 1'b1;
            result.fwd[3] = 1'b0;
         end
      end else if (rot_mode) begin
         for (int k = 0; k < NumWheels; k++) begin
            sum = $signed({2'b00, five_a} + {4'b0000, dead_width[k], 2'b00});
            result.duty[k] = duty_sat(sum);
         end
         result.fwd = {NumWheels{~t[7]}};
      end
   end

endmodule
`default_nettype wire
